// ===== rtl/dht_pkg.sv =====
// Shared types, constants and codes for the double hash table unit.
package dht_pkg;

  localparam int MAX_SLOTS  = 1024;
  localparam int SLOT_BITS  = $clog2(MAX_SLOTS);
  localparam int SIZE_BITS  = SLOT_BITS + 1;
  localparam int KEY_BITS   = 32;
  localparam int VALUE_BITS = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_UPDATED   = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_USED  = 2'd1;
  localparam logic [1:0] MARK_GONE  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] key;
    logic [31:0] value;
  } dht_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] found_value;
    logic [9:0]  slot_index;
  } dht_out_t;

  // A classified item as handed from the front part to the back part.
  typedef struct packed {
    logic [1:0]           command;
    logic [KEY_BITS-1:0]  key;
    logic [VALUE_BITS-1:0] value;
    logic [SLOT_BITS-1:0] home;
    logic [SLOT_BITS-1:0] step;
    logic [SIZE_BITS-1:0] size;
  } dht_job_t;

  typedef enum logic [2:0] {
    FS_IDLE, FS_HOME, FS_STEP, FS_PUSH
  } dht_front_state_t;

  typedef enum logic [2:0] {
    BS_CLEAR, BS_IDLE, BS_READ, BS_CHECK, BS_WRITE, BS_DONE
  } dht_back_state_t;

endpackage

// ===== rtl/dht_front.sv =====
// Front part: takes commands, computes home slot and probe step by serial modulo.
module dht_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       take,
  input  dht_pkg::dht_in_t           item,
  input  logic [dht_pkg::SIZE_BITS-1:0] size,
  output logic                       idle,
  output logic                       job_valid,
  output dht_pkg::dht_job_t          job,
  input  logic                       job_ready
);
  import dht_pkg::*;

  dht_front_state_t state_r, state_nxt;
  dht_in_t          item_r;
  logic [SIZE_BITS-1:0] size_r;
  logic [SIZE_BITS-1:0] rem_r, rem_nxt;
  logic [SIZE_BITS-1:0] div_r;
  logic [5:0]           bit_r, bit_nxt;
  logic [SLOT_BITS-1:0] home_r;
  logic [SIZE_BITS:0]   shifted;
  logic [SIZE_BITS:0]   diff;

  // One restoring-division step per cycle, key bits taken from the top.
  always_comb begin
    shifted = {rem_r, item_r.key[bit_r[4:0]]};
    diff    = shifted - {1'b0, div_r};
    if (!diff[SIZE_BITS]) begin
      rem_nxt = diff[SIZE_BITS-1:0];
    end else begin
      rem_nxt = shifted[SIZE_BITS-1:0];
    end
  end

  always_comb begin
    state_nxt = state_r;
    bit_nxt   = bit_r - 6'd1;
    unique case (state_r)
      FS_IDLE: if (take) state_nxt = FS_HOME;
      FS_HOME: if (bit_r == 6'd0) state_nxt = FS_STEP;
      FS_STEP: if (bit_r == 6'd0) state_nxt = FS_PUSH;
      FS_PUSH: if (job_ready) state_nxt = FS_IDLE;
      default: state_nxt = FS_IDLE;
    endcase
    if (state_r == FS_IDLE || (state_r == FS_HOME && bit_r == 6'd0)) begin
      bit_nxt = 6'(KEY_BITS - 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    bit_r <= bit_nxt;
    unique case (state_r)
      FS_IDLE: begin
        item_r <= item;
        if (size < SIZE_BITS'(3)) begin
          size_r <= SIZE_BITS'(3);
          div_r  <= SIZE_BITS'(3);
        end else if (size > SIZE_BITS'(MAX_SLOTS)) begin
          size_r <= SIZE_BITS'(MAX_SLOTS);
          div_r  <= SIZE_BITS'(MAX_SLOTS);
        end else begin
          size_r <= size;
          div_r  <= size;
        end
        rem_r <= '0;
      end
      FS_HOME: begin
        if (bit_r == 6'd0) begin
          home_r <= rem_nxt[SLOT_BITS-1:0];
          rem_r  <= '0;
          div_r  <= size_r - SIZE_BITS'(1);
        end else begin
          rem_r <= rem_nxt;
        end
      end
      FS_STEP: rem_r <= rem_nxt;
      FS_PUSH: ;
      default: ;
    endcase
  end

  always_comb begin
    idle        = (state_r == FS_IDLE);
    job_valid   = (state_r == FS_PUSH);
    job.command = item_r.command;
    job.key     = item_r.key;
    job.value   = item_r.value;
    job.home    = home_r;
    job.step    = rem_r[SLOT_BITS-1:0] + SLOT_BITS'(1);
    job.size    = size_r;
  end
endmodule

// ===== rtl/dht_queue.sv =====
// Short queue between the front and back parts.
module dht_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_ready,
  input  dht_pkg::dht_job_t wr_data,
  output logic              rd_valid,
  input  logic              rd_ready,
  output dht_pkg::dht_job_t rd_data
);
  import dht_pkg::*;

  localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

  dht_job_t            mem_r [QUEUE_DEPTH];
  logic [PTR_BITS-1:0] wp_r, rp_r;
  logic [PTR_BITS:0]   cnt_r;
  logic                push, pop;

  assign wr_ready = (cnt_r != (PTR_BITS+1)'(QUEUE_DEPTH));
  assign rd_valid = (cnt_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PTR_BITS'(1);
      if (pop) rp_r <= rp_r + PTR_BITS'(1);
      cnt_r <= cnt_r + (PTR_BITS+1)'(push) - (PTR_BITS+1)'(pop);
    end
    if (push) mem_r[wp_r] <= wr_data;
  end
endmodule

// ===== rtl/dht_back.sv =====
// Back part: walks the probe sequence through the slot memories and writes results.
module dht_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  dht_pkg::dht_job_t job,
  output logic              ready_n,
  output logic              res_valid,
  output dht_pkg::dht_out_t res
);
  import dht_pkg::*;

  dht_back_state_t state_r, state_nxt;
  dht_job_t        job_r;

  logic [KEY_BITS-1:0]   keys_mem [MAX_SLOTS];
  logic [VALUE_BITS-1:0] vals_mem [MAX_SLOTS];
  logic [1:0]            marks_mem [MAX_SLOTS];

  logic [KEY_BITS-1:0]   key_q;
  logic [VALUE_BITS-1:0] val_q;
  logic [1:0]            mark_q;

  logic [SLOT_BITS-1:0] idx_r, idx_nxt;
  logic [SIZE_BITS-1:0] cnt_r;
  logic [SLOT_BITS-1:0] clr_r;
  logic                 free_v_r;
  logic [SLOT_BITS-1:0] free_r;
  logic [SIZE_BITS:0]   idx_sum;

  // Final action chosen in the check stage.
  logic                 wr_key, wr_val, wr_mark;
  logic [1:0]           wmark;
  logic [SLOT_BITS-1:0] waddr;
  logic                 wr_key_r, wr_val_r, wr_mark_r;
  logic [1:0]           wmark_r;
  logic [SLOT_BITS-1:0] waddr_r;
  dht_out_t             res_nxt, res_r;
  logic                 finish;
  logic                 last_probe;
  logic                 hit;

  assign idx_sum = {1'b0, idx_r} + {1'b0, job_r.step};
  always_comb begin
    if (idx_sum >= {1'b0, job_r.size}) begin
      idx_nxt = SLOT_BITS'(idx_sum - {1'b0, job_r.size});
    end else begin
      idx_nxt = idx_sum[SLOT_BITS-1:0];
    end
  end

  assign last_probe = (cnt_r == job_r.size - SIZE_BITS'(1));
  assign hit        = (mark_q == MARK_USED) && (key_q == job_r.key);

  always_comb begin
    finish  = 1'b0;
    wr_key  = 1'b0;
    wr_val  = 1'b0;
    wr_mark = 1'b0;
    wmark   = MARK_USED;
    waddr   = idx_r;
    res_nxt = '{status: ST_NOT_FOUND, found_value: '0, slot_index: '0};
    if (hit) begin
      finish = 1'b1;
      case (job_r.command)
        CMD_INSERT: begin
          wr_val  = 1'b1;
          res_nxt = '{status: ST_UPDATED, found_value: '0, slot_index: idx_r};
        end
        CMD_SEARCH: res_nxt = '{status: ST_FOUND, found_value: val_q, slot_index: idx_r};
        CMD_REMOVE: begin
          wr_mark = 1'b1;
          wmark   = MARK_GONE;
          res_nxt = '{status: ST_REMOVED, found_value: '0, slot_index: idx_r};
        end
        default: ;
      endcase
    end else if (mark_q == MARK_EMPTY || last_probe) begin
      finish = 1'b1;
      if (job_r.command == CMD_INSERT) begin
        if (free_v_r || mark_q != MARK_USED) begin
          waddr   = free_v_r ? free_r : idx_r;
          wr_key  = 1'b1;
          wr_val  = 1'b1;
          wr_mark = 1'b1;
          res_nxt = '{status: ST_INSERTED, found_value: '0, slot_index: waddr};
        end else begin
          res_nxt = '{status: ST_FULL, found_value: '0, slot_index: '0};
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_CLEAR: if (clr_r == SLOT_BITS'(MAX_SLOTS - 1)) state_nxt = BS_IDLE;
      BS_IDLE:  if (job_valid) state_nxt = BS_READ;
      BS_READ:  state_nxt = BS_CHECK;
      BS_CHECK: state_nxt = finish ? BS_WRITE : BS_READ;
      BS_WRITE: state_nxt = BS_DONE;
      BS_DONE:  state_nxt = BS_IDLE;
      default:  state_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    job_ready = (state_r == BS_IDLE);
    ready_n   = (state_r == BS_CLEAR);
    res_valid = (state_r == BS_DONE);
    res       = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BS_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == BS_CLEAR) clr_r <= clr_r + SLOT_BITS'(1);
    end
    if (state_r == BS_IDLE) begin
      job_r    <= job;
      idx_r    <= job.home;
      cnt_r    <= '0;
      free_v_r <= 1'b0;
    end
    if (state_r == BS_CHECK) begin
      if (!finish) begin
        idx_r <= idx_nxt;
        cnt_r <= cnt_r + SIZE_BITS'(1);
        if (!free_v_r && mark_q != MARK_USED) begin
          free_v_r <= 1'b1;
          free_r   <= idx_r;
        end
      end
      wr_key_r  <= finish && wr_key;
      wr_val_r  <= finish && wr_val;
      wr_mark_r <= finish && wr_mark;
      wmark_r   <= wmark;
      waddr_r   <= waddr;
      res_r     <= res_nxt;
    end
  end

  // Slot memories: one read port, one write port each.
  always_ff @(posedge clk) begin
    key_q  <= keys_mem[idx_r];
    val_q  <= vals_mem[idx_r];
    mark_q <= marks_mem[idx_r];
    if (state_r == BS_CLEAR) begin
      marks_mem[clr_r] <= MARK_EMPTY;
    end else if (state_r == BS_WRITE && wr_mark_r) begin
      marks_mem[waddr_r] <= wmark_r;
    end
    if (state_r == BS_WRITE && wr_key_r) keys_mem[waddr_r] <= job_r.key;
    if (state_r == BS_WRITE && wr_val_r) vals_mem[waddr_r] <= job_r.value;
  end
endmodule

// ===== rtl/double_hash_table_unit.sv =====
// Top level of the double hash table unit.
// Open-addressing key/value table with double hashing.
// Commands enter on in_data when start is high and busy is low; each command
// is one transaction with fields command, key and value.
// Every command produces exactly one result, shown on out_data for one cycle
// with out_valid high. The receiver cannot stall the block.
// The front part computes home slot and probe step, one after the other, with a
// bit-serial modulo; it takes the next command while the back part is still
// probing the previous one, as long as the queue between them has room.
// Each probe in the back part passes a read state (memory read) and then a
// check state (compare); a finished command then passes a write state and a
// done state that reports the result.
// The user must write the table size on the cfg channel only while the block
// is idle; the block itself does not enforce this. After reset the block clears
// every slot mark with busy high, and configuration writes are taken meanwhile.
module double_hash_table_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  dht_pkg::dht_in_t                   in_data,
  output logic                               out_valid,
  output dht_pkg::dht_out_t                  out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [dht_pkg::SIZE_BITS-1:0]      cfg_table_size
);
  import dht_pkg::*;

  logic [SIZE_BITS-1:0] size_r;
  logic                 f_idle, f_valid, f_ready, b_valid, b_ready, clearing;
  dht_job_t             f_job, b_job;

  assign cfg_ready = 1'b1;
  assign busy      = !f_idle || clearing;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_BITS'(MAX_SLOTS);
    end else if (cfg_valid && cfg_ready) begin
      size_r <= cfg_table_size;
    end
  end

  dht_front u_front (
    .clk, .rst_n, .take(start && !busy), .item(in_data), .size(size_r),
    .idle(f_idle), .job_valid(f_valid), .job(f_job), .job_ready(f_ready)
  );

  dht_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_job),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_job)
  );

  dht_back u_back (
    .clk, .rst_n, .job_valid(b_valid), .job_ready(b_ready), .job(b_job),
    .ready_n(clearing), .res_valid(out_valid), .res(out_data)
  );
endmodule

// ===== rtl/dht_checker.sv =====
// Port-level checker for the double hash table unit, bound to the top level.
module dht_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_valid,
  input dht_pkg::dht_out_t out_data
);
  import dht_pkg::*;

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy not raised after accepted command");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.status <= ST_FULL) else $error("status code out of range");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_FOUND |-> out_data.found_value == '0)
    else $error("found_value nonzero without found");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_NOT_FOUND || out_data.status == ST_FULL)
    |-> out_data.slot_index == '0) else $error("slot_index nonzero with no slot");

  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
endmodule

bind double_hash_table_unit dht_checker u_dht_checker (
  .clk, .rst_n, .start, .busy, .out_valid, .out_data
);
